// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that holds at every clock edge out of reset
`define FLA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fla assertion failed");

// antecedent in this cycle implies consequent in the next
`define FLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fla assertion failed");

`else

`define FLA_ASSERT(label, clk, rst_n, prop)
`define FLA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/fla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_pkg
// types and constants of the free list page allocator
// ----------------------------------------------------------------------------
package fla_pkg;

    localparam int PAGE_COUNT = 1024;
    localparam int PAGE_W     = 10;
    localparam int ADDR_W     = $clog2(PAGE_COUNT);
    localparam int HEAD_W     = $clog2(PAGE_COUNT + 1);
    localparam int STATUS_W   = 2;

    localparam logic [HEAD_W-1:0] LIST_END  = HEAD_W'(PAGE_COUNT);
    localparam logic [HEAD_W-1:0] FIRST_PG  = HEAD_W'(1);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_OUT_OF_PAGES = 2'd1,
        ST_IGNORED      = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_POP  = 1'b1
    } t_state;

    typedef struct packed {
        logic              operation;
        logic [PAGE_W-1:0] page;
    } t_req;

    typedef struct packed {
        logic [PAGE_W-1:0]   granted_page;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    // link store access from the controller
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [HEAD_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_link_req;

endpackage

// File: rtl/free_list_page_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_page_allocator_core
// page allocator with linked free list and bump pointer, page 0 reserved
// ----------------------------------------------------------------------------
// usage:
//   request beat on i_in_valid / o_in_stall carries operation and page;
//   each request gives exactly one response beat on o_out_valid / i_out_stall
//   with granted_page and status (ok, out of pages, free ignored).
//   the response is registered (output register, or the skid entry behind it).
//   frees, bump and failed allocations leave the controller idle; a pop from
//   the free list passes the pop state, which stalls the input, since the next
//   head comes back through the registered read port of the link store.
//   the response path has an output register plus one skid entry, so one
//   request is still taken while a response waits; with both full the
//   input stalls until the receiver takes a beat.
//   reset (synchronous, active low) empties the free list, sets the bump
//   pointer to page 1 and drops any pending responses; the link store
//   needs no clearing, entries are only read after being written.
// ----------------------------------------------------------------------------
module free_list_page_allocator_core
    import fla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    t_link_req         link;
    logic [HEAD_W-1:0] link_rd_data;

    fla_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_data      (i_in_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data),
        .o_link         (link),
        .i_link_rd_data (link_rd_data)
    );

    fla_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (PAGE_COUNT)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link.wr_en),
        .i_wr_addr (link.wr_addr),
        .i_wr_data (link.wr_data),
        .i_rd_en   (link.rd_en),
        .i_rd_addr (link.rd_addr),
        .o_rd_data (link_rd_data)
    );

endmodule

// File: rtl/fla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/fla_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// fla_ctrl
// request sequencer: head and bump pointer, link store access, result buffer
// ----------------------------------------------------------------------------
module fla_ctrl
    import fla_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_req              i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_rsp              o_out_data,
    output t_link_req         o_link,
    input  logic [HEAD_W-1:0] i_link_rd_data
);

    t_state            r_state, n_state;
    logic [HEAD_W-1:0] r_head, n_head;
    logic [HEAD_W-1:0] r_bump, n_bump;
    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    t_rsp              r_out, n_out;
    t_rsp              r_skid, n_skid;

    logic      accept;
    logic      out_take;
    logic      list_nonempty;
    logic      pg_invalid;
    logic      pop_start;
    t_rsp      res;
    t_link_req link;

    assign o_in_stall    = (r_state != S_IDLE) || r_skid_valid;
    assign accept        = i_in_valid && !o_in_stall;
    assign out_take      = r_out_valid && !i_out_stall;
    assign list_nonempty = r_head < LIST_END;
    assign pg_invalid    = (i_in_data.page == '0)
                        || ({1'b0, i_in_data.page} >= LIST_END);
    assign pop_start     = accept && list_nonempty
                        && (t_op'(i_in_data.operation) == OP_ALLOC);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_bump       = r_bump;
        res          = '0;
        link         = '0;
        link.wr_addr = i_in_data.page[ADDR_W-1:0];
        link.wr_data = r_head;
        link.rd_addr = r_head[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_op'(i_in_data.operation) == OP_ALLOC) begin
                        if (list_nonempty) begin
                            // grant now, new head arrives from the link store
                            res.granted_page = r_head[PAGE_W-1:0];
                            res.status       = ST_OK;
                            link.rd_en       = 1'b1;
                            n_state          = S_POP;
                        end else if (r_bump < LIST_END) begin
                            res.granted_page = r_bump[PAGE_W-1:0];
                            res.status       = ST_OK;
                            n_bump           = r_bump + HEAD_W'(1);
                        end else begin
                            res.status = ST_OUT_OF_PAGES;
                        end
                    end else begin
                        if (pg_invalid) begin
                            res.status = ST_IGNORED;
                        end else begin
                            res.status  = ST_OK;
                            link.wr_en  = 1'b1;
                            n_head      = {1'b0, i_in_data.page};
                        end
                    end
                end
            end
            S_POP: begin
                n_head  = i_link_rd_data;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // two-entry result buffer, accept only with the skid slot empty
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (accept) begin
            if (!r_out_valid || out_take) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out        = r_skid;
            n_out_valid  = r_skid_valid;
            n_skid_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= LIST_END;
            r_bump       <= FIRST_PG;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_bump       <= n_bump;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_link      = link;

    `FLA_ASSERT(a_bump_range, i_clk, i_rst_n, (r_bump >= FIRST_PG) && (r_bump <= LIST_END))
    `FLA_ASSERT(a_skid_behind_out, i_clk, i_rst_n, !r_skid_valid || r_out_valid)
    `FLA_ASSERT_NEXT(a_pop_one_cycle, i_clk, i_rst_n, r_state == S_POP, r_state == S_IDLE)
    `FLA_ASSERT_NEXT(a_pop_follows, i_clk, i_rst_n, pop_start, r_state == S_POP && r_out_valid)
    `FLA_ASSERT(a_no_link_rw_together, i_clk, i_rst_n, !(link.wr_en && link.rd_en))

endmodule

// File: sim/fla_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_alloc_checker
// watches the request and response channels of the page allocator, keeps
// its own free list, bump pointer and link store, and compares every
// response beat with the oldest predicted grant and status
// ----------------------------------------------------------------------------
module fla_alloc_checker
    import fla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_req i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_rsp i_out_data,
    output int   o_errors,
    output int   o_pending
);

    logic [HEAD_W-1:0] list_head;
    logic [HEAD_W-1:0] bump_page;
    logic [HEAD_W-1:0] next_free [PAGE_COUNT];
    t_rsp              owed_rsp_q [$];
    int                fail_cnt = 0;

    // applies one request to the shadow allocator and gives its response
    function automatic t_rsp serve_request(input t_req req);
        t_rsp rsp;
        rsp.granted_page = '0;
        rsp.status       = ST_OK;
        if (t_op'(req.operation) == OP_ALLOC) begin
            if (list_head < LIST_END) begin
                rsp.granted_page = list_head[PAGE_W-1:0];
                list_head        = next_free[list_head[ADDR_W-1:0]];
            end else if (bump_page < LIST_END) begin
                rsp.granted_page = bump_page[PAGE_W-1:0];
                bump_page        = bump_page + HEAD_W'(1);
            end else begin
                rsp.status = ST_OUT_OF_PAGES;
            end
        end else if (req.page == '0 || HEAD_W'(req.page) >= LIST_END) begin
            rsp.status = ST_IGNORED;
        end else begin
            next_free[req.page[ADDR_W-1:0]] = list_head;
            list_head                       = HEAD_W'(req.page);
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            list_head = LIST_END;
            bump_page = FIRST_PG;
            owed_rsp_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_rsp_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("[%0t] response beat with nothing owed: page %0d status %0d",
                                 $time, i_out_data.granted_page, i_out_data.status);
                    end
                end else begin
                    want = owed_rsp_q.pop_front();
                    if (i_out_data.granted_page !== want.granted_page ||
                        i_out_data.status !== want.status) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("[%0t] mismatch: expected page %0d status %0d,",
                                     $time, want.granted_page, want.status,
                                     " got page %0d status %0d",
                                     i_out_data.granted_page, i_out_data.status);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                owed_rsp_q.push_back(serve_request(i_in_data));
            end
        end
        o_errors  <= fail_cnt;
        o_pending <= owed_rsp_q.size();
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the page allocator: directed frees and allocations, then
// random traffic that frees only held pages or page 0, runs the pool dry, refills
// it, and finishes with double frees; the checker judges every response
// ----------------------------------------------------------------------------
module tb_top;
    import fla_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam logic [PAGE_W-1:0] TOP_PAGE = PAGE_W'(PAGE_COUNT - 1);

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_req in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_rsp out_data;

    int          errors;
    int          pending;
    int unsigned cycle_cnt = 0;

    // pages the stimulus holds and may free without a double free
    logic [PAGE_W-1:0] held_q [$];
    bit                held_map [PAGE_COUNT];
    bit                tracking = 1'b0;
    int                oop_seen = 0;

    bit calm    = 1'b0;
    int gap_pct = 30;
    int stall_left = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    free_list_page_allocator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    fla_alloc_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // receiver stalls in bursts of random length between runs
    always @(posedge clk) begin
        if (calm) begin
            out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (out_stall) begin
            out_stall  <= 1'b0;
            stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 12);
        end else if ($urandom_range(0, 3) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end
    end

    // learn granted pages and pool exhaustion from response beats
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (out_data.status == ST_OUT_OF_PAGES) begin
                oop_seen <= oop_seen + 1;
            end else if (tracking && out_data.status == ST_OK &&
                         out_data.granted_page != '0 &&
                         out_data.granted_page != TOP_PAGE &&
                         !held_map[out_data.granted_page]) begin
                held_map[out_data.granted_page] = 1'b1;
                held_q.push_back(out_data.granted_page);
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("free_list_page_allocator_core test failed");
            $finish;
        end
    end

    task automatic send(input t_op op, input logic [PAGE_W-1:0] pg);
        int gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 10) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{operation: op, page: pg};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [PAGE_W-1:0] take_held();
        int                idx;
        logic [PAGE_W-1:0] pg;
        idx = $urandom_range(0, held_q.size() - 1);
        pg  = held_q[idx];
        held_q.delete(idx);
        held_map[pg] = 1'b0;
        return pg;
    endfunction

    task automatic send_mix(input int alloc_pct, input int zero_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < zero_pct) begin
            send(OP_FREE, '0);
        end else if (roll < zero_pct + alloc_pct || held_q.size() == 0) begin
            send(OP_ALLOC, PAGE_W'($urandom_range(0, PAGE_COUNT - 1)));
        end else begin
            send(OP_FREE, take_held());
        end
    endtask

    initial begin
        int                n;
        logic [PAGE_W-1:0] twice_pg;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bump grants with junk in the page field
        send(OP_ALLOC, '0);
        send(OP_ALLOC, TOP_PAGE);
        send(OP_ALLOC, PAGE_W'($urandom_range(0, PAGE_COUNT - 1)));
        send(OP_FREE, '0);
        // push and pop through the link store
        send(OP_FREE, PAGE_W'(2));
        send(OP_ALLOC, '0);
        send(OP_FREE, PAGE_W'(1));
        send(OP_FREE, PAGE_W'(3));
        send(OP_ALLOC, TOP_PAGE);
        send(OP_ALLOC, '0);
        send(OP_ALLOC, TOP_PAGE);
        // free of a page not yet handed out, then pop it back
        send(OP_FREE, TOP_PAGE);
        send(OP_ALLOC, PAGE_W'(10'h2AA));
        send(OP_FREE, '0);
        send(OP_ALLOC, PAGE_W'(10'h155));
        wait_idle();
        tracking = 1'b1;

        for (n = 0; n < 60; n++) send_mix(55, 10);
        wait_idle();

        // run the pool dry, mostly allocations
        gap_pct = 20;
        n = 0;
        while (oop_seen == 0 && n < 3000) begin
            send_mix(94, 2);
            n++;
        end
        for (n = 0; n < 10; n++) send(OP_ALLOC, PAGE_W'($urandom_range(0, PAGE_COUNT - 1)));

        gap_pct = 30;
        for (n = 0; n < 60; n++) send_mix(55, 5);
        wait_idle();

        // last part without idling: double frees form a cycle in the list
        calm    = 1'b1;
        gap_pct = 0;
        if (held_q.size() != 0) begin
            twice_pg = take_held();
            send(OP_FREE, twice_pg);
            send(OP_FREE, twice_pg);
            repeat (4) send(OP_ALLOC, PAGE_W'($urandom_range(0, PAGE_COUNT - 1)));
        end
        for (n = 0; n < 30; n++) send_mix(50, 5);
        wait_idle();
        repeat (10) @(posedge clk);

        if (errors == 0 && pending == 0) begin
            $display("free_list_page_allocator_core test passed");
        end else begin
            $display("free_list_page_allocator_core test failed");
        end
        $finish;
    end

endmodule
